### src/efrc_pkg.sv
// ----------------------------------------------------------------------------
// efrc_pkg
// shared types, codes and constants of the epoch fenced route controller
// ----------------------------------------------------------------------------
package efrc_pkg;

  localparam int unsigned DefMaxNodes   = 16;
  localparam int unsigned DefMaxDevices = 16;
  localparam int unsigned DefMaxSlots   = 16;

  localparam int unsigned TimeoutW = 63;
  localparam int unsigned InDataW  = 280;
  localparam int unsigned OutDataW = 152;

  localparam logic [63:0] EpochMax = '1;

  typedef enum logic [3:0] {
    ST_OK, ST_INVALID, ST_NOT_ENROLLED, ST_STALE_INC, ST_STALE_REV,
    ST_STALE_EPOCH, ST_WRONG_STATE, ST_SLOT_BUSY, ST_BAD_CONFIG, ST_EXHAUSTED
  } status_e;

  typedef enum logic [2:0] {
    RS_UNASSIGNED, RS_DETACHING, RS_ATTACHING, RS_ACTIVE, RS_FAULT
  } rmode_e;

  typedef enum logic [3:0] {
    K_ENROLL_SRC, K_ENROLL_DST, K_OBSERVE_DEV, K_OBSERVE_SLOT, K_REQUEST,
    K_RELEASE, K_DETACHED, K_ATTACHED, K_FAULT, K_CLEAR, K_TICK, K_QUERY
  } kind_e;

  typedef enum logic {
    CFG_DETACH_TIMEOUT, CFG_ATTACH_TIMEOUT
  } cfg_reg_e;

  typedef struct packed {
    logic [4:0]  node;
    logic [31:0] inc;
    logic [31:0] rev;
  } endpoint_t;

  typedef struct packed {
    logic [4:0] slot;
    endpoint_t  ep;
  } slotref_t;

  typedef struct packed {
    rmode_e      mode;
    logic [63:0] epoch;
    logic [63:0] deadline;
    logic        act_f;
    slotref_t    act;
    logic        pend_f;
    slotref_t    pend;
    logic        observed;
    logic        ever_seen;
    endpoint_t   owner;
  } dev_rec_t;

  // last field in the lowest bits
  typedef struct packed {
    logic [63:0] claimed_epoch;
    logic [31:0] dst_revision;
    logic [31:0] dst_incarnation;
    logic [4:0]  dst_node;
    logic [4:0]  slot_index;
    logic [31:0] src_revision;
    logic [31:0] src_incarnation;
    logic [4:0]  src_node;
    logic [4:0]  device_index;
    logic [63:0] now_tick;
    logic [3:0]  kind;
  } item_t;

  typedef struct packed {
    logic [4:0]  pad;
    logic [63:0] deadline_out;
    logic [4:0]  pending_slot_out;
    logic        pending_present;
    logic [4:0]  active_slot_out;
    logic        active_present;
    logic [63:0] route_epoch_out;
    logic [2:0]  route_mode;
    logic [3:0]  status;
  } result_t;

  typedef struct packed {
    logic capture;
    logic scan1;
    logic decide;
    logic scan2;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } sts_t;

endpackage

### src/epoch_fenced_route_controller.sv
// ----------------------------------------------------------------------------
// epoch_fenced_route_controller
// per-device route records with epoch fencing of stale endpoints
// ----------------------------------------------------------------------------
// usage
//   items arrive on the s_axis beat group, one command per beat; each gives
//   exactly one result beat on m_axis describing the addressed route
//   timeouts are written through cfg_we_i / cfg_idx_i / cfg_data_i while idle
// item sequence
//   one item at a time: after the accept, a scan over all device records, a
//   decision step, an update scan over all device records and a result load;
//   the load waits while the output register is full and not being taken
// reset
//   all enrolment, observation and route records clear at once; every route
//   is unassigned with epoch and deadline zero, both timeouts zero
// stalls
//   the result sits in an output register; the next item is accepted while
//   it waits, and its own result is held back until the receiver takes it
// ----------------------------------------------------------------------------
module epoch_fenced_route_controller import efrc_pkg::*; #(
  parameter int unsigned MAX_NODES   = DefMaxNodes,
  parameter int unsigned MAX_DEVICES = DefMaxDevices,
  parameter int unsigned MAX_SLOTS   = DefMaxSlots
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // kind, now_tick, device_index, src_node, src_incarnation, src_revision,
  // slot_index, dst_node, dst_incarnation, dst_revision, claimed_epoch
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // status, route_mode, route_epoch_out, active_present, active_slot_out,
  // pending_present, pending_slot_out, deadline_out, zero fill
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // 0 detach_timeout, 1 attach_timeout
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [TimeoutW-1:0] cfg_data_i
);

  localparam int unsigned DevIdxW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;

  cmd_t               cmd;
  sts_t               sts;
  logic [DevIdxW-1:0] scan_idx;
  result_t            result;

  // command sequencer
  efrc_ctrl #(
    .MaxDevices (MAX_DEVICES),
    .DevIdxW    (DevIdxW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .scan_idx_o  (scan_idx)
  );

  // records, decision logic and result register
  efrc_dpath #(
    .MaxNodes   (MAX_NODES),
    .MaxDevices (MAX_DEVICES),
    .MaxSlots   (MAX_SLOTS),
    .DevIdxW    (DevIdxW)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item_t'(s_axis_tdata)),
    .cmd_i       (cmd),
    .scan_idx_i  (scan_idx),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (result)
  );

  assign m_axis_tdata = OutDataW'(result);

endmodule

### src/efrc_ctrl.sv
// ----------------------------------------------------------------------------
// efrc_ctrl
// sequencer: capture, record scan, decision, update scan, result load
// ----------------------------------------------------------------------------
module efrc_ctrl import efrc_pkg::*; #(
  parameter int unsigned MaxDevices = DefMaxDevices,
  parameter int unsigned DevIdxW    = (MaxDevices > 1) ? $clog2(MaxDevices) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               out_ready_i,
  input  sts_t               sts_i,
  output cmd_t               cmd_o,
  output logic [DevIdxW-1:0] scan_idx_o
);

  typedef enum logic [2:0] {S_IDLE, S_SCAN1, S_DECIDE, S_SCAN2, S_LOAD} state_e;

  localparam logic [DevIdxW-1:0] LastIdx = DevIdxW'(MaxDevices - 1);

  state_e             state_q;
  logic [DevIdxW-1:0] cnt_q;
  logic               load_ok;

  assign load_ok = !sts_i.out_full || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (in_valid_i) state_q <= S_SCAN1;
        end
        S_SCAN1: begin
          if (cnt_q == LastIdx) begin
            cnt_q   <= '0;
            state_q <= S_DECIDE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_DECIDE: state_q <= S_SCAN2;
        S_SCAN2: begin
          if (cnt_q == LastIdx) begin
            cnt_q   <= '0;
            state_q <= S_LOAD;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_LOAD: begin
          if (load_ok) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign cmd_o.capture  = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.scan1    = (state_q == S_SCAN1);
  assign cmd_o.decide   = (state_q == S_DECIDE);
  assign cmd_o.scan2    = (state_q == S_SCAN2);
  assign cmd_o.load     = (state_q == S_LOAD) && load_ok;
  assign scan_idx_o     = cnt_q;

  a_capture_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == S_SCAN1) && (cnt_q == '0))
    else $error("capture not followed by record scan");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LastIdx)
    else $error("scan index beyond last record");
  a_decide_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.decide |=> cmd_o.scan2 && (cnt_q == '0))
    else $error("decision not followed by update scan");
  a_load_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == S_LOAD) |-> $past(cmd_o.scan2))
    else $error("result loaded without update scan");

endmodule

### src/efrc_dpath.sv
// ----------------------------------------------------------------------------
// efrc_dpath
// route, enrolment and slot records with the scan and decision logic
// ----------------------------------------------------------------------------
module efrc_dpath import efrc_pkg::*; #(
  parameter int unsigned MaxNodes   = DefMaxNodes,
  parameter int unsigned MaxDevices = DefMaxDevices,
  parameter int unsigned MaxSlots   = DefMaxSlots,
  parameter int unsigned DevIdxW    = (MaxDevices > 1) ? $clog2(MaxDevices) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [TimeoutW-1:0] cfg_data_i,
  input  item_t               item_i,
  input  cmd_t                cmd_i,
  input  logic [DevIdxW-1:0]  scan_idx_i,
  output sts_t                sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output result_t             out_o
);

  localparam int unsigned NodeIdxW = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;
  localparam int unsigned SlotIdxW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;

  logic [TimeoutW-1:0] det_to_q, att_to_q;
  item_t               item_q;
  dev_rec_t            recs_q [MaxDevices];
  logic                src_enr_q [MaxNodes];
  logic [31:0]         src_inc_q [MaxNodes];
  logic [31:0]         src_rev_q [MaxNodes];
  logic                dst_enr_q [MaxNodes];
  logic [31:0]         dst_inc_q [MaxNodes];
  logic [31:0]         dst_rev_q [MaxNodes];
  logic                slot_obs_q [MaxSlots];
  endpoint_t           slot_own_q [MaxSlots];

  logic     exh_q, busy_q, fence_q, tick_q, wr_i_q;
  status_e  st_q;
  dev_rec_t rec_new_q;
  logic     out_valid_q;
  result_t  out_q;

  // decoded request
  endpoint_t           src_ep, dst_ep;
  slotref_t            sr;
  logic                dev_ok, src_ok, dst_ok, slot_ok, cfg_ok, is_src;
  logic [DevIdxW-1:0]  dev_idx, rd_idx;
  logic [NodeIdxW-1:0] node_idx;
  logic [SlotIdxW-1:0] slot_idx;
  logic [4:0]          fnode;
  dev_rec_t            rec_rd;
  kind_e               kind;

  assign kind    = kind_e'(item_q.kind);
  assign src_ep  = '{node: item_q.src_node, inc: item_q.src_incarnation,
                     rev: item_q.src_revision};
  assign dst_ep  = '{node: item_q.dst_node, inc: item_q.dst_incarnation,
                     rev: item_q.dst_revision};
  assign sr      = '{slot: item_q.slot_index, ep: dst_ep};
  assign dev_ok  = (item_q.device_index != '0) && (int'(item_q.device_index) <= MaxDevices);
  assign slot_ok = (item_q.slot_index != '0) && (int'(item_q.slot_index) <= MaxSlots);
  assign src_ok  = (src_ep.node != '0) && (int'(src_ep.node) <= MaxNodes) &&
                   (src_ep.inc != '0) && (src_ep.rev != '0);
  assign dst_ok  = (dst_ep.node != '0) && (int'(dst_ep.node) <= MaxNodes) &&
                   (dst_ep.inc != '0) && (dst_ep.rev != '0);
  assign cfg_ok  = (det_to_q != '0) && (att_to_q != '0);
  assign is_src  = (kind == K_ENROLL_SRC) || (kind == K_OBSERVE_DEV);
  assign fnode   = is_src ? src_ep.node : dst_ep.node;
  assign dev_idx = dev_ok ? DevIdxW'(item_q.device_index - 5'd1) : '0;
  assign node_idx = ((fnode != '0) && (int'(fnode) <= MaxNodes))
                    ? NodeIdxW'(fnode - 5'd1) : '0;
  assign slot_idx = slot_ok ? SlotIdxW'(item_q.slot_index - 5'd1) : '0;
  assign rd_idx  = (cmd_i.scan1 || cmd_i.scan2) ? scan_idx_i : dev_idx;
  assign rec_rd  = recs_q[rd_idx];

  // node and slot table reads
  logic        n_enr;
  logic [31:0] n_inc, n_rev;
  logic        s_obs;
  endpoint_t   s_own;

  assign n_enr = is_src ? src_enr_q[node_idx] : dst_enr_q[node_idx];
  assign n_inc = is_src ? src_inc_q[node_idx] : dst_inc_q[node_idx];
  assign n_rev = is_src ? src_rev_q[node_idx] : dst_rev_q[node_idx];
  assign s_obs = slot_obs_q[slot_idx];
  assign s_own = slot_own_q[slot_idx];

  // per record scan terms
  logic     uses, skip, hit;
  slotref_t tgt;
  logic [4:0] except_dev;

  always_comb begin
    if (kind == K_ENROLL_SRC) begin
      uses = (rec_rd.mode != RS_UNASSIGNED) && (rec_rd.owner.node == fnode);
    end else begin
      uses = (rec_rd.act_f && (rec_rd.act.ep.node == fnode)) ||
             (rec_rd.pend_f && (rec_rd.pend.ep.node == fnode));
    end
    tgt        = (kind == K_OBSERVE_SLOT) ? '{slot: item_q.slot_index, ep: s_own} : sr;
    except_dev = (kind == K_OBSERVE_SLOT) ? 5'd0 : item_q.device_index;
    skip = rec_rd.ever_seen ? ((int'(scan_idx_i) + 1) == int'(except_dev))
                            : (except_dev == 5'd0);
    hit  = !skip && ((rec_rd.act_f && (rec_rd.act == tgt)) ||
                     (rec_rd.pend_f && (rec_rd.pend == tgt)));
  end

  // device and slot checks shared by several kinds
  status_e chk_dev, chk_slot;

  always_comb begin
    if (!dev_ok || !src_ok)                     chk_dev = ST_INVALID;
    else if (!rec_rd.observed)                  chk_dev = ST_NOT_ENROLLED;
    else if (src_ep.node != rec_rd.owner.node)  chk_dev = ST_INVALID;
    else if (src_ep.inc != rec_rd.owner.inc)    chk_dev = ST_STALE_INC;
    else if (src_ep.rev != rec_rd.owner.rev)    chk_dev = ST_STALE_REV;
    else                                        chk_dev = ST_OK;
    if (!slot_ok || !dst_ok)                    chk_slot = ST_INVALID;
    else if (!s_obs)                            chk_slot = ST_NOT_ENROLLED;
    else if (dst_ep.node != s_own.node)         chk_slot = ST_INVALID;
    else if (dst_ep.inc != s_own.inc)           chk_slot = ST_STALE_INC;
    else if (dst_ep.rev != s_own.rev)           chk_slot = ST_STALE_REV;
    else                                        chk_slot = ST_OK;
  end

  // decision on the addressed route
  status_e  d_st;
  logic     d_fence, d_tick, d_wr, d_node_wr, d_slot_wr;
  dev_rec_t d_rec;
  logic     changed;
  logic [63:0] now_det, now_att, ep_inc;

  assign now_det = item_q.now_tick + {1'b0, det_to_q};
  assign now_att = item_q.now_tick + {1'b0, att_to_q};
  assign ep_inc  = rec_rd.epoch + 64'd1;
  assign changed = n_enr && ((item_q.kind == K_ENROLL_SRC ? src_ep.inc : dst_ep.inc) != n_inc ||
                             (item_q.kind == K_ENROLL_SRC ? src_ep.rev : dst_ep.rev) != n_rev);

  always_comb begin
    endpoint_t e;
    e         = (kind == K_ENROLL_SRC || kind == K_OBSERVE_DEV) ? src_ep : dst_ep;
    d_st      = ST_OK;
    d_fence   = 1'b0;
    d_tick    = 1'b0;
    d_wr      = 1'b0;
    d_node_wr = 1'b0;
    d_slot_wr = 1'b0;
    d_rec     = rec_rd;
    unique case (item_q.kind)
      K_ENROLL_SRC, K_ENROLL_DST: begin
        if (!cfg_ok) d_st = ST_BAD_CONFIG;
        else if (!(is_src ? src_ok : dst_ok)) d_st = ST_INVALID;
        else if (n_enr && e.inc < n_inc) d_st = ST_STALE_INC;
        else if (n_enr && e.inc == n_inc && e.rev < n_rev) d_st = ST_STALE_REV;
        else if (changed && exh_q) d_st = ST_EXHAUSTED;
        else begin
          d_node_wr = 1'b1;
          d_fence   = changed;
        end
      end
      K_OBSERVE_DEV: begin
        if (!dev_ok || !src_ok) d_st = ST_INVALID;
        else if (!n_enr) d_st = ST_NOT_ENROLLED;
        else if (src_ep.inc != n_inc) d_st = ST_STALE_INC;
        else if (src_ep.rev != n_rev) d_st = ST_STALE_REV;
        else if (rec_rd.observed && rec_rd.owner.node != src_ep.node) d_st = ST_INVALID;
        else if (rec_rd.observed && rec_rd.mode != RS_UNASSIGNED &&
                 rec_rd.mode != RS_FAULT &&
                 (rec_rd.owner.inc != src_ep.inc || rec_rd.owner.rev != src_ep.rev))
          d_st = ST_WRONG_STATE;
        else begin
          d_wr            = 1'b1;
          d_rec.owner     = src_ep;
          d_rec.observed  = 1'b1;
          d_rec.ever_seen = 1'b1;
        end
      end
      K_OBSERVE_SLOT: begin
        if (!slot_ok || !dst_ok) d_st = ST_INVALID;
        else if (!n_enr) d_st = ST_NOT_ENROLLED;
        else if (dst_ep.inc != n_inc) d_st = ST_STALE_INC;
        else if (dst_ep.rev != n_rev) d_st = ST_STALE_REV;
        else if (s_obs && s_own.node != dst_ep.node) d_st = ST_INVALID;
        else if (s_obs && s_own != dst_ep && busy_q) d_st = ST_WRONG_STATE;
        else d_slot_wr = 1'b1;
      end
      K_REQUEST: begin
        if (!cfg_ok) d_st = ST_BAD_CONFIG;
        else if (chk_dev != ST_OK) d_st = chk_dev;
        else if (chk_slot != ST_OK) d_st = chk_slot;
        else if (rec_rd.mode == RS_ACTIVE && rec_rd.act_f && rec_rd.act == sr) d_st = ST_OK;
        else if (rec_rd.mode != RS_UNASSIGNED && rec_rd.mode != RS_ACTIVE)
          d_st = ST_WRONG_STATE;
        else if (busy_q) d_st = ST_SLOT_BUSY;
        else if (rec_rd.epoch == EpochMax) d_st = ST_EXHAUSTED;
        else begin
          d_wr         = 1'b1;
          d_rec.epoch  = ep_inc;
          d_rec.pend   = sr;
          d_rec.pend_f = 1'b1;
          if (rec_rd.mode == RS_ACTIVE) begin
            d_rec.mode     = RS_DETACHING;
            d_rec.deadline = now_det;
          end else begin
            d_rec.mode     = RS_ATTACHING;
            d_rec.deadline = now_att;
          end
        end
      end
      K_RELEASE: begin
        if (chk_dev != ST_OK) d_st = chk_dev;
        else if (rec_rd.mode == RS_UNASSIGNED) d_st = ST_OK;
        else if (rec_rd.mode != RS_ACTIVE) d_st = ST_WRONG_STATE;
        else if (rec_rd.epoch == EpochMax) d_st = ST_EXHAUSTED;
        else begin
          d_wr           = 1'b1;
          d_rec.epoch    = ep_inc;
          d_rec.mode     = RS_DETACHING;
          d_rec.deadline = now_det;
          d_rec.pend_f   = 1'b0;
        end
      end
      K_DETACHED: begin
        if (chk_dev != ST_OK) d_st = chk_dev;
        else if (item_q.claimed_epoch != rec_rd.epoch) d_st = ST_STALE_EPOCH;
        else if (rec_rd.mode != RS_DETACHING) d_st = ST_WRONG_STATE;
        else begin
          d_wr        = 1'b1;
          d_rec.act_f = 1'b0;
          if (!rec_rd.pend_f) begin
            d_rec.mode     = RS_UNASSIGNED;
            d_rec.deadline = '0;
          end else begin
            d_rec.mode     = RS_ATTACHING;
            d_rec.deadline = now_att;
          end
        end
      end
      K_ATTACHED: begin
        if (chk_dev != ST_OK) d_st = chk_dev;
        else if (chk_slot != ST_OK) d_st = chk_slot;
        else if (item_q.claimed_epoch != rec_rd.epoch) d_st = ST_STALE_EPOCH;
        else if (rec_rd.mode != RS_ATTACHING || !rec_rd.pend_f || rec_rd.pend != sr)
          d_st = ST_WRONG_STATE;
        else begin
          d_wr           = 1'b1;
          d_rec.act      = sr;
          d_rec.act_f    = 1'b1;
          d_rec.pend_f   = 1'b0;
          d_rec.mode     = RS_ACTIVE;
          d_rec.deadline = '0;
        end
      end
      K_FAULT: begin
        if (chk_dev != ST_OK) d_st = chk_dev;
        else if (item_q.claimed_epoch != rec_rd.epoch) d_st = ST_STALE_EPOCH;
        else begin
          d_wr           = 1'b1;
          d_rec.mode     = RS_FAULT;
          d_rec.act_f    = 1'b0;
          d_rec.pend_f   = 1'b0;
          d_rec.deadline = '0;
        end
      end
      K_CLEAR: begin
        if (chk_dev != ST_OK) d_st = chk_dev;
        else if (rec_rd.mode != RS_FAULT) d_st = ST_WRONG_STATE;
        else if (rec_rd.epoch == EpochMax) d_st = ST_EXHAUSTED;
        else begin
          d_wr           = 1'b1;
          d_rec.epoch    = ep_inc;
          d_rec.mode     = RS_UNASSIGNED;
          d_rec.deadline = '0;
        end
      end
      K_TICK:  d_tick = 1'b1;
      K_QUERY: d_st = dev_ok ? ST_OK : ST_INVALID;
      default: d_st = ST_WRONG_STATE;
    endcase
  end

  // update applied to record under scan
  dev_rec_t upd;
  logic [63:0] diff;

  assign diff = item_q.now_tick - rec_rd.deadline;

  always_comb begin
    upd = rec_rd;
    if (fence_q) begin
      if (uses) begin
        upd.epoch    = rec_rd.epoch + 64'd1;
        upd.mode     = RS_FAULT;
        upd.act_f    = 1'b0;
        upd.pend_f   = 1'b0;
        upd.deadline = '0;
      end
      if (kind == K_ENROLL_SRC && rec_rd.observed && rec_rd.owner.node == fnode)
        upd.observed = 1'b0;
    end
    if (tick_q && (rec_rd.mode == RS_ATTACHING || rec_rd.mode == RS_DETACHING) &&
        !diff[63]) begin
      upd.mode     = RS_FAULT;
      upd.act_f    = 1'b0;
      upd.pend_f   = 1'b0;
      upd.deadline = '0;
    end
    if (wr_i_q && dev_ok && scan_idx_i == dev_idx) upd = rec_new_q;
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= item_i;
    if (cmd_i.decide) begin
      st_q      <= d_st;
      rec_new_q <= d_rec;
    end
    if (cmd_i.load) begin
      out_q.pad    <= '0;
      out_q.status <= st_q;
      if (dev_ok) begin
        out_q.route_mode       <= rec_rd.mode;
        out_q.route_epoch_out  <= rec_rd.epoch;
        out_q.active_present   <= rec_rd.act_f;
        out_q.active_slot_out  <= rec_rd.act_f ? rec_rd.act.slot : 5'd0;
        out_q.pending_present  <= rec_rd.pend_f;
        out_q.pending_slot_out <= rec_rd.pend_f ? rec_rd.pend.slot : 5'd0;
        out_q.deadline_out     <= rec_rd.deadline;
      end else begin
        out_q.route_mode       <= RS_FAULT;
        out_q.route_epoch_out  <= '0;
        out_q.active_present   <= 1'b0;
        out_q.active_slot_out  <= '0;
        out_q.pending_present  <= 1'b0;
        out_q.pending_slot_out <= '0;
        out_q.deadline_out     <= '0;
      end
    end
  end

  // state records and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_to_q    <= '0;
      att_to_q    <= '0;
      exh_q       <= 1'b0;
      busy_q      <= 1'b0;
      fence_q     <= 1'b0;
      tick_q      <= 1'b0;
      wr_i_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MaxDevices; i++) recs_q[i] <= '0;
      for (int i = 0; i < MaxNodes; i++) begin
        src_enr_q[i] <= 1'b0;
        src_inc_q[i] <= '0;
        src_rev_q[i] <= '0;
        dst_enr_q[i] <= 1'b0;
        dst_inc_q[i] <= '0;
        dst_rev_q[i] <= '0;
      end
      for (int i = 0; i < MaxSlots; i++) begin
        slot_obs_q[i] <= 1'b0;
        slot_own_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_DETACH_TIMEOUT) det_to_q <= cfg_data_i;
        else                                 att_to_q <= cfg_data_i;
      end
      if (cmd_i.capture) begin
        exh_q   <= 1'b0;
        busy_q  <= 1'b0;
        fence_q <= 1'b0;
        tick_q  <= 1'b0;
        wr_i_q  <= 1'b0;
      end
      if (cmd_i.scan1) begin
        if (uses && rec_rd.epoch == EpochMax) exh_q <= 1'b1;
        if (hit) busy_q <= 1'b1;
      end
      if (cmd_i.decide) begin
        fence_q <= d_fence;
        tick_q  <= d_tick;
        wr_i_q  <= d_wr;
        if (d_node_wr) begin
          if (kind == K_ENROLL_SRC) begin
            src_enr_q[node_idx] <= 1'b1;
            src_inc_q[node_idx] <= src_ep.inc;
            src_rev_q[node_idx] <= src_ep.rev;
          end else begin
            dst_enr_q[node_idx] <= 1'b1;
            dst_inc_q[node_idx] <= dst_ep.inc;
            dst_rev_q[node_idx] <= dst_ep.rev;
          end
        end
        if (d_fence && kind == K_ENROLL_DST) begin
          for (int i = 0; i < MaxSlots; i++)
            if (slot_obs_q[i] && slot_own_q[i].node == fnode) slot_obs_q[i] <= 1'b0;
        end
        if (d_slot_wr) begin
          slot_obs_q[slot_idx] <= 1'b1;
          slot_own_q[slot_idx] <= dst_ep;
        end
      end
      if (cmd_i.scan2) recs_q[scan_idx_i] <= upd;
      if (cmd_i.load)       out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_full = out_valid_q;
  assign out_valid_o    = out_valid_q;
  assign out_o          = out_q;

  a_fence_xor_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fence_q && tick_q) && !(fence_q && wr_i_q) && !(tick_q && wr_i_q))
    else $error("more than one update kind armed");
  a_exhausted_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.decide && d_fence |-> !exh_q)
    else $error("fence armed with an exhausted epoch");
  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> out_valid_q)
    else $error("result load lost");

endmodule

### tb/sv/epoch_fenced_route_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_fenced_route_controller_tb
// self-checking bench for the epoch fenced route controller
// ----------------------------------------------------------------------------
// a behavioural route table in the bench follows every accepted command beat
// and predicts the one result beat it gives; results are compared field by
// field in order; directed commands walk the route life cycle, then random
// well-formed sessions with noise run under random gaps on both sides and
// one long receiver hold-off
// ----------------------------------------------------------------------------
module epoch_fenced_route_controller_tb;
  import efrc_pkg::*;

  localparam int unsigned NDev = 16;
  localparam int unsigned NNode = 16;
  localparam int unsigned NSlot = 16;
  localparam int unsigned ItemLat = 2 * NDev + 4;
  localparam longint unsigned CycleLimit = 600000;

  typedef struct {
    logic [4:0]  node;
    logic [31:0] inc;
    logic [31:0] rev;
  } ept_t;

  // behavioural route table and expected result beats
  class route_scoreboard;
    logic [62:0] det_to, att_to;
    bit          s_enr[NNode], d_enr[NNode];
    logic [31:0] s_inc[NNode], s_rev[NNode], d_inc[NNode], d_rev[NNode];
    bit          obs[NDev], seen[NDev];
    ept_t        owner[NDev];
    rmode_e      mode[NDev];
    logic [63:0] ep[NDev], dl[NDev];
    bit          af[NDev], pf[NDev];
    logic [4:0]  aslot[NDev], pslot[NDev];
    ept_t        aep[NDev], pep[NDev];
    bit          sobs[NSlot];
    ept_t        sown[NSlot];
    result_t     pending_results[$];
    int          errors;

    function new();
      det_to = '0; att_to = '0; errors = 0;
      for (int i = 0; i < NNode; i++) begin
        s_enr[i] = 0; d_enr[i] = 0; s_inc[i] = '0; s_rev[i] = '0;
        d_inc[i] = '0; d_rev[i] = '0;
      end
      for (int i = 0; i < NDev; i++) begin
        obs[i] = 0; seen[i] = 0; owner[i] = '{default: '0}; mode[i] = RS_UNASSIGNED;
        ep[i] = '0; dl[i] = '0; af[i] = 0; pf[i] = 0; aslot[i] = '0; pslot[i] = '0;
        aep[i] = '{default: '0}; pep[i] = '{default: '0};
      end
      for (int i = 0; i < NSlot; i++) begin
        sobs[i] = 0; sown[i] = '{default: '0};
      end
    endfunction

    function void write_reg(cfg_reg_e idx, logic [62:0] v);
      if (idx == CFG_DETACH_TIMEOUT) det_to = v;
      else att_to = v;
    endfunction

    function bit ep_ok(ept_t e);
      return e.node >= 1 && e.node <= NNode && e.inc != 0 && e.rev != 0;
    endfunction

    function bit ep_eq(ept_t a, ept_t b);
      return a.node == b.node && a.inc == b.inc && a.rev == b.rev;
    endfunction

    function void to_fault(int i);
      mode[i] = RS_FAULT; af[i] = 0; pf[i] = 0; dl[i] = '0;
    endfunction

    function status_e dev_check(logic [4:0] dev, ept_t s);
      int i;
      if (dev < 1 || dev > NDev || !ep_ok(s)) return ST_INVALID;
      i = dev - 1;
      if (!obs[i]) return ST_NOT_ENROLLED;
      if (s.node != owner[i].node) return ST_INVALID;
      if (s.inc != owner[i].inc) return ST_STALE_INC;
      if (s.rev != owner[i].rev) return ST_STALE_REV;
      return ST_OK;
    endfunction

    function status_e slot_check(logic [4:0] sl, ept_t d);
      int k;
      if (sl < 1 || sl > NSlot || !ep_ok(d)) return ST_INVALID;
      k = sl - 1;
      if (!sobs[k]) return ST_NOT_ENROLLED;
      if (d.node != sown[k].node) return ST_INVALID;
      if (d.inc != sown[k].inc) return ST_STALE_INC;
      if (d.rev != sown[k].rev) return ST_STALE_REV;
      return ST_OK;
    endfunction

    // records never observed carry id 0, so a skip of 0 passes over them
    function bit busy(logic [4:0] sl, ept_t d, int skip);
      int id;
      for (int i = 0; i < NDev; i++) begin
        id = seen[i] ? i + 1 : 0;
        if (id == skip) continue;
        if (af[i] && aslot[i] == sl && ep_eq(aep[i], d)) return 1;
        if (pf[i] && pslot[i] == sl && ep_eq(pep[i], d)) return 1;
      end
      return 0;
    endfunction

    function bit uses(bit is_src, int i, logic [4:0] node);
      if (is_src) return mode[i] != RS_UNASSIGNED && owner[i].node == node;
      return (af[i] && aep[i].node == node) || (pf[i] && pep[i].node == node);
    endfunction

    function status_e enrol(bit is_src, ept_t e);
      int n;
      logic [31:0] ki, kr;
      bit en;
      if (det_to == 0 || att_to == 0) return ST_BAD_CONFIG;
      if (!ep_ok(e)) return ST_INVALID;
      n = e.node - 1;
      en = is_src ? s_enr[n] : d_enr[n];
      ki = is_src ? s_inc[n] : d_inc[n];
      kr = is_src ? s_rev[n] : d_rev[n];
      if (en && e.inc < ki) return ST_STALE_INC;
      if (en && e.inc == ki && e.rev < kr) return ST_STALE_REV;
      if (en && (e.inc != ki || e.rev != kr)) begin
        for (int i = 0; i < NDev; i++)
          if (uses(is_src, i, e.node) && ep[i] == EpochMax) return ST_EXHAUSTED;
        for (int i = 0; i < NDev; i++) begin
          if (uses(is_src, i, e.node)) begin
            ep[i] = ep[i] + 1;
            to_fault(i);
          end
          if (is_src && obs[i] && owner[i].node == e.node) obs[i] = 0;
        end
        if (!is_src)
          for (int k = 0; k < NSlot; k++)
            if (sobs[k] && sown[k].node == e.node) sobs[k] = 0;
      end
      if (is_src) begin
        s_inc[n] = e.inc; s_rev[n] = e.rev; s_enr[n] = 1;
      end else begin
        d_inc[n] = e.inc; d_rev[n] = e.rev; d_enr[n] = 1;
      end
      return ST_OK;
    endfunction

    function void begin_attach(int i, logic [63:0] now, logic [4:0] sl, ept_t d);
      pslot[i] = sl; pep[i] = d; pf[i] = 1; mode[i] = RS_ATTACHING;
      dl[i] = now + {1'b0, att_to};
    endfunction

    // apply one command beat and queue the result it gives
    function void note_command(item_t it);
      status_e st;
      ept_t s, d;
      logic [4:0] dev, sl;
      logic [63:0] now, diff;
      bit dok;
      int i, k;
      result_t r;
      st = ST_OK;
      dev = it.device_index; sl = it.slot_index; now = it.now_tick;
      s = '{it.src_node, it.src_incarnation, it.src_revision};
      d = '{it.dst_node, it.dst_incarnation, it.dst_revision};
      dok = dev >= 1 && dev <= NDev;
      i = dok ? dev - 1 : 0;
      case (it.kind)
        K_ENROLL_SRC: st = enrol(1, s);
        K_ENROLL_DST: st = enrol(0, d);
        K_OBSERVE_DEV: begin
          k = s.node - 1;
          if (!dok || !ep_ok(s)) st = ST_INVALID;
          else if (!s_enr[k]) st = ST_NOT_ENROLLED;
          else if (s.inc != s_inc[k]) st = ST_STALE_INC;
          else if (s.rev != s_rev[k]) st = ST_STALE_REV;
          else if (obs[i] && owner[i].node != s.node) st = ST_INVALID;
          else if (obs[i] && mode[i] != RS_UNASSIGNED && mode[i] != RS_FAULT &&
                   (owner[i].inc != s.inc || owner[i].rev != s.rev))
            st = ST_WRONG_STATE;
          else begin
            owner[i] = s; obs[i] = 1; seen[i] = 1;
          end
        end
        K_OBSERVE_SLOT: begin
          k = d.node - 1;
          if (sl < 1 || sl > NSlot || !ep_ok(d)) st = ST_INVALID;
          else if (!d_enr[k]) st = ST_NOT_ENROLLED;
          else if (d.inc != d_inc[k]) st = ST_STALE_INC;
          else if (d.rev != d_rev[k]) st = ST_STALE_REV;
          else if (sobs[sl-1] && sown[sl-1].node != d.node) st = ST_INVALID;
          else if (sobs[sl-1] && !ep_eq(sown[sl-1], d) && busy(sl, sown[sl-1], 0))
            st = ST_WRONG_STATE;
          else begin
            sown[sl-1] = d; sobs[sl-1] = 1;
          end
        end
        K_REQUEST: begin
          if (det_to == 0 || att_to == 0) st = ST_BAD_CONFIG;
          else begin
            st = dev_check(dev, s);
            if (st == ST_OK) st = slot_check(sl, d);
            if (st == ST_OK && !(mode[i] == RS_ACTIVE && af[i] && aslot[i] == sl &&
                                 ep_eq(aep[i], d))) begin
              if (mode[i] != RS_UNASSIGNED && mode[i] != RS_ACTIVE) st = ST_WRONG_STATE;
              else if (busy(sl, d, dev)) st = ST_SLOT_BUSY;
              else if (ep[i] == EpochMax) st = ST_EXHAUSTED;
              else begin
                ep[i] = ep[i] + 1;
                pslot[i] = sl; pep[i] = d; pf[i] = 1;
                if (mode[i] == RS_ACTIVE) begin
                  mode[i] = RS_DETACHING; dl[i] = now + {1'b0, det_to};
                end else begin_attach(i, now, sl, d);
              end
            end
          end
        end
        K_RELEASE: begin
          st = dev_check(dev, s);
          if (st == ST_OK && mode[i] != RS_UNASSIGNED) begin
            if (mode[i] != RS_ACTIVE) st = ST_WRONG_STATE;
            else if (ep[i] == EpochMax) st = ST_EXHAUSTED;
            else begin
              ep[i] = ep[i] + 1; mode[i] = RS_DETACHING;
              dl[i] = now + {1'b0, det_to}; pf[i] = 0;
            end
          end
        end
        K_DETACHED: begin
          st = dev_check(dev, s);
          if (st == ST_OK) begin
            if (it.claimed_epoch != ep[i]) st = ST_STALE_EPOCH;
            else if (mode[i] != RS_DETACHING) st = ST_WRONG_STATE;
            else begin
              af[i] = 0;
              if (!pf[i]) begin
                mode[i] = RS_UNASSIGNED; dl[i] = '0;
              end else begin_attach(i, now, pslot[i], pep[i]);
            end
          end
        end
        K_ATTACHED: begin
          st = dev_check(dev, s);
          if (st == ST_OK) st = slot_check(sl, d);
          if (st == ST_OK) begin
            if (it.claimed_epoch != ep[i]) st = ST_STALE_EPOCH;
            else if (mode[i] != RS_ATTACHING || !pf[i] || pslot[i] != sl ||
                     !ep_eq(pep[i], d)) st = ST_WRONG_STATE;
            else begin
              aslot[i] = sl; aep[i] = d; af[i] = 1; pf[i] = 0;
              mode[i] = RS_ACTIVE; dl[i] = '0;
            end
          end
        end
        K_FAULT: begin
          st = dev_check(dev, s);
          if (st == ST_OK) begin
            if (it.claimed_epoch != ep[i]) st = ST_STALE_EPOCH;
            else to_fault(i);
          end
        end
        K_CLEAR: begin
          st = dev_check(dev, s);
          if (st == ST_OK) begin
            if (mode[i] != RS_FAULT) st = ST_WRONG_STATE;
            else if (ep[i] == EpochMax) st = ST_EXHAUSTED;
            else begin
              ep[i] = ep[i] + 1; mode[i] = RS_UNASSIGNED; dl[i] = '0;
            end
          end
        end
        K_TICK: begin
          // expiry by the sign of now minus deadline
          for (int j = 0; j < NDev; j++) begin
            diff = now - dl[j];
            if ((mode[j] == RS_ATTACHING || mode[j] == RS_DETACHING) && !diff[63])
              to_fault(j);
          end
        end
        K_QUERY: st = dok ? ST_OK : ST_INVALID;
        default: st = ST_WRONG_STATE;
      endcase
      r = '0;
      r.status = st;
      if (dok) begin
        r.route_mode = mode[i];
        r.route_epoch_out = ep[i];
        r.active_present = af[i];
        r.active_slot_out = af[i] ? aslot[i] : '0;
        r.pending_present = pf[i];
        r.pending_slot_out = pf[i] ? pslot[i] : '0;
        r.deadline_out = dl[i];
      end else r.route_mode = RS_FAULT;
      pending_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with none expected, actual %h", $time, got);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (got.status !== e.status)
        $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
      if (got.route_mode !== e.route_mode)
        $display("%0t: route_mode expected %0d actual %0d", $time, e.route_mode,
                 got.route_mode);
      if (got.route_epoch_out !== e.route_epoch_out)
        $display("%0t: route_epoch_out expected %h actual %h", $time,
                 e.route_epoch_out, got.route_epoch_out);
      if (got.active_present !== e.active_present)
        $display("%0t: active_present expected %b actual %b", $time,
                 e.active_present, got.active_present);
      if (got.active_slot_out !== e.active_slot_out)
        $display("%0t: active_slot_out expected %0d actual %0d", $time,
                 e.active_slot_out, got.active_slot_out);
      if (got.pending_present !== e.pending_present)
        $display("%0t: pending_present expected %b actual %b", $time,
                 e.pending_present, got.pending_present);
      if (got.pending_slot_out !== e.pending_slot_out)
        $display("%0t: pending_slot_out expected %0d actual %0d", $time,
                 e.pending_slot_out, got.pending_slot_out);
      if (got.deadline_out !== e.deadline_out)
        $display("%0t: deadline_out expected %h actual %h", $time, e.deadline_out,
                 got.deadline_out);
      if (got !== e) errors++;
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_idx_i = 1'b0;
  logic [TimeoutW-1:0] cfg_data_i = '0;

  route_scoreboard routes = new();
  longint unsigned cycle_count = 0;
  bit              stimulus_done = 0;
  bit              hold_off = 0;

  // bench-side identities of each node, bumped now and then
  logic [31:0] src_inc_id[NNode], src_rev_id[NNode];
  logic [31:0] dst_inc_id[NNode], dst_rev_id[NNode];
  logic [63:0] now_clock = 64'd1000;

  epoch_fenced_route_controller dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[epoch_fenced_route_controller] ERROR");
      $finish;
    end
  end

  // output side: random stall per beat, long hold-off when asked
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) routes.check_result(result_t'(m_axis_tdata));
  end

  initial begin : receiver
    int gap;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      // the beat is taken at this edge; ready is reconsidered next loop
    end
  end

  // valid stays up into the next beat when no gap follows
  task automatic send_beat(item_t it, bit no_gaps);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata <= it;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    routes.note_command(it);
  endtask

  task automatic write_timeout(cfg_reg_e idx, logic [62:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    routes.write_reg(idx, v);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (routes.pending_results.size() != 0) @(posedge clk_i);
    repeat (ItemLat) @(posedge clk_i);
  endtask

  function automatic item_t make_cmd(kind_e k, int dev, int src, int sl, int dst,
                                     logic [63:0] ce);
    item_t it;
    it = '0;
    it.kind = k;
    it.now_tick = now_clock;
    it.device_index = 5'(dev);
    it.src_node = 5'(src);
    it.slot_index = 5'(sl);
    it.dst_node = 5'(dst);
    it.claimed_epoch = ce;
    if (src >= 1 && src <= NNode) begin
      it.src_incarnation = src_inc_id[src-1];
      it.src_revision = src_rev_id[src-1];
    end
    if (dst >= 1 && dst <= NNode) begin
      it.dst_incarnation = dst_inc_id[dst-1];
      it.dst_revision = dst_rev_id[dst-1];
    end
    return it;
  endfunction

  // noisy command: every field drawn at random
  function automatic item_t noise_cmd();
    item_t it;
    it.kind = 4'($urandom_range(0, 15));
    it.now_tick = {$urandom, $urandom};
    it.device_index = 5'($urandom);
    it.src_node = 5'($urandom);
    it.src_incarnation = $urandom;
    it.src_revision = $urandom;
    it.slot_index = 5'($urandom);
    it.dst_node = 5'($urandom);
    it.dst_incarnation = $urandom;
    it.dst_revision = $urandom;
    it.claimed_epoch = {$urandom, $urandom};
    return it;
  endfunction

  // well-formed command on the current bench identities, epochs taken from
  // the route table so that confirmations mostly land
  function automatic item_t session_cmd();
    item_t it;
    int dev, src, sl, dst, pick;
    kind_e k;
    logic [63:0] ce;
    dev = $urandom_range(1, 6);
    src = ((dev - 1) % 3) + 1;
    sl = $urandom_range(1, 6);
    dst = ((sl - 1) % 3) + 1;
    pick = $urandom_range(0, 99);
    if (pick < 4) k = K_ENROLL_SRC;
    else if (pick < 8) k = K_ENROLL_DST;
    else if (pick < 18) k = K_OBSERVE_DEV;
    else if (pick < 28) k = K_OBSERVE_SLOT;
    else if (pick < 48) k = K_REQUEST;
    else if (pick < 54) k = K_RELEASE;
    else if (pick < 64) k = K_DETACHED;
    else if (pick < 76) k = K_ATTACHED;
    else if (pick < 80) k = K_FAULT;
    else if (pick < 88) k = K_CLEAR;
    else if (pick < 95) k = K_TICK;
    else k = K_QUERY;
    ce = routes.ep[dev-1];
    if ($urandom_range(0, 9) == 0) ce = ce ^ (64'd1 << $urandom_range(0, 63));
    if (k == K_ATTACHED && routes.pf[dev-1] && $urandom_range(0, 3) != 0) begin
      sl = routes.pslot[dev-1];
      dst = routes.pep[dev-1].node;
    end
    it = make_cmd(k, dev, src, sl, dst, ce);
    if (k == K_ATTACHED && routes.pf[dev-1] && dst == routes.pep[dev-1].node) begin
      it.dst_incarnation = routes.pep[dev-1].inc;
      it.dst_revision = routes.pep[dev-1].rev;
    end
    return it;
  endfunction

  // newer identity: a revision step or a new incarnation, with even odds
  task automatic bump_identity(bit is_src, int node);
    if (is_src) begin
      if ($urandom_range(0, 1)) src_rev_id[node-1] = src_rev_id[node-1] + 1;
      else begin
        src_inc_id[node-1] = src_inc_id[node-1] + 1; src_rev_id[node-1] = 1;
      end
    end else begin
      if ($urandom_range(0, 1)) dst_rev_id[node-1] = dst_rev_id[node-1] + 1;
      else begin
        dst_inc_id[node-1] = dst_inc_id[node-1] + 1; dst_rev_id[node-1] = 1;
      end
    end
  endtask

  initial begin : stimulus
    item_t it;
    logic [62:0] dsets[4], asets[4];
    int n;
    for (int i = 0; i < NNode; i++) begin
      src_inc_id[i] = 5; src_rev_id[i] = 3; dst_inc_id[i] = 7; dst_rev_id[i] = 2;
    end
    // top node uses the widest identities
    src_inc_id[NNode-1] = '1; src_rev_id[NNode-1] = '1;
    dst_inc_id[NNode-1] = '1; dst_rev_id[NNode-1] = '1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: bad config first, then a full attach/detach/fault cycle
    send_beat(make_cmd(K_ENROLL_SRC, 1, 1, 0, 0, 0), 1);
    send_beat(make_cmd(K_REQUEST, 1, 1, 1, 1, 0), 1);
    wait_drained();
    write_timeout(CFG_DETACH_TIMEOUT, 63'd40);
    write_timeout(CFG_ATTACH_TIMEOUT, 63'd50);
    send_beat(make_cmd(K_ENROLL_SRC, 1, 1, 0, 0, 0), 1);
    send_beat(make_cmd(K_ENROLL_SRC, 16, 16, 0, 0, 0), 1);
    send_beat(make_cmd(K_ENROLL_DST, 0, 0, 0, 1, 0), 1);
    send_beat(make_cmd(K_ENROLL_DST, 0, 0, 0, 16, 0), 1);
    send_beat(make_cmd(K_OBSERVE_DEV, 1, 1, 0, 0, 0), 1);
    send_beat(make_cmd(K_OBSERVE_DEV, 16, 16, 0, 0, 0), 1);
    send_beat(make_cmd(K_OBSERVE_SLOT, 0, 0, 1, 1, 0), 1);
    send_beat(make_cmd(K_OBSERVE_SLOT, 0, 0, 16, 16, 0), 1);
    send_beat(make_cmd(K_REQUEST, 1, 1, 1, 1, 0), 1);
    send_beat(make_cmd(K_REQUEST, 16, 16, 1, 1, 0), 1);      // slot busy
    send_beat(make_cmd(K_ATTACHED, 1, 1, 1, 1, 64'd1), 1);
    send_beat(make_cmd(K_REQUEST, 1, 1, 16, 16, 0), 1);
    send_beat(make_cmd(K_DETACHED, 1, 1, 0, 0, 64'd0), 1);   // stale epoch
    send_beat(make_cmd(K_DETACHED, 1, 1, 0, 0, 64'd2), 1);
    now_clock = 64'd2000;
    send_beat(make_cmd(K_TICK, 1, 0, 0, 0, 0), 1);           // expiry
    send_beat(make_cmd(K_CLEAR, 1, 1, 0, 0, 0), 1);
    send_beat(make_cmd(K_FAULT, 16, 16, 0, 0, 64'd0), 1);
    send_beat(make_cmd(K_QUERY, 0, 0, 0, 0, 0), 1);          // invalid device
    send_beat(make_cmd(K_QUERY, 17, 0, 0, 0, 0), 1);
    it = make_cmd(K_QUERY, 31, 0, 0, 0, 0);
    it.kind = 4'd15;                                           // unused kind
    send_beat(it, 1);
    bump_identity(1, 16);
    send_beat(make_cmd(K_ENROLL_SRC, 0, 16, 0, 0, 0), 1);    // bumped identity wraps to zero, invalid
    wait_drained();

    // random phases across timeout settings, extremes included; deadlines
    // near the wrap exercise the signed compare
    dsets = '{63'd1, 63'h7FFF_FFFF_FFFF_FFFF, 63'd300, 63'd0};
    asets = '{63'd1, 63'h7FFF_FFFF_FFFF_FFFF, 63'd0, 63'd500};
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        write_timeout(CFG_DETACH_TIMEOUT, dsets[ph-1]);
        write_timeout(CFG_ATTACH_TIMEOUT, asets[ph-1]);
      end
      if (ph == 2) now_clock = 64'hFFFF_FFFF_FFFF_FF00;
      for (n = 0; n < 300; n++) begin
        if (n == 150 && ph == 1) hold_off = 1;
        now_clock = now_clock + $urandom_range(0, 200);
        if ($urandom_range(0, 49) == 0) bump_identity(1'($urandom_range(0, 1)),
                                                      $urandom_range(1, 3));
        if ($urandom_range(0, 9) == 0) it = noise_cmd();
        else it = session_cmd();
        send_beat(it, ($urandom_range(0, 4) == 0));
      end
      wait_drained();
    end
    stimulus_done = 1;
  end

  initial begin : finisher
    wait (stimulus_done);
    if (routes.errors == 0 && routes.pending_results.size() == 0)
      $display("[epoch_fenced_route_controller] OK");
    else
      $display("[epoch_fenced_route_controller] ERROR");
    $finish;
  end

endmodule

### filelist.f
src/efrc_pkg.sv
src/efrc_ctrl.sv
src/efrc_dpath.sv
src/epoch_fenced_route_controller.sv
tb/sv/epoch_fenced_route_controller_tb.sv
